// File: src/dral_pkg.sv
// ----------------------------------------------------------------------------
// dral_pkg
// Shared types and constants for the deduplicating ring-log allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package dral_pkg;

  localparam int MAX_ENTRY_BYTES_DEF = 4096;
  localparam int HEADER_BYTES_DEF    = 48;
  localparam int SOURCE_SLOTS_DEF    = 32;

  localparam int DIG_W  = 64;
  localparam int TIME_W = 32;
  localparam int UID_W  = 32;
  localparam int SIZE_W = 16;
  localparam int OFF_W  = 24;
  localparam int RND_W  = SIZE_W + 1;

  localparam logic [31:0]    ROUND_MASK     = 32'hffff_fff8;
  localparam logic [OFF_W-1:0] RING_START   = OFF_W'(8);
  localparam logic [OFF_W-1:0] RING_SIZE_RST = OFF_W'(131072);

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_DUP    = 2'd1,
    ST_SIZE   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] write_offset;
    logic [OFF_W-1:0] prev_offset;
    logic [OFF_W-1:0] end_offset;
  } res_t;

endpackage

`default_nettype wire

// File: src/dral_dedup.sv
// ----------------------------------------------------------------------------
// dral_dedup
// Per-source table of newest (time, id); associative lookup and update.
// ----------------------------------------------------------------------------
`default_nettype none

module dral_dedup #(
  parameter int SOURCE_SLOTS = dral_pkg::SOURCE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [dral_pkg::DIG_W-1:0]    origin_hash,
  input  logic [dral_pkg::TIME_W-1:0]   event_time,
  input  logic [dral_pkg::UID_W-1:0]    sequence_uid,
  output dral_pkg::status_t             dd_status
);
  import dral_pkg::*;

  logic [SOURCE_SLOTS-1:0] slot_vld_r;
  logic [DIG_W-1:0]        slot_dig_r  [SOURCE_SLOTS];
  logic [TIME_W-1:0]       slot_time_r [SOURCE_SLOTS];
  logic [UID_W-1:0]        slot_uid_r  [SOURCE_SLOTS];

  logic [SOURCE_SLOTS-1:0] hit;
  logic [SOURCE_SLOTS-1:0] newer;
  logic [SOURCE_SLOTS-1:0] upd_we;
  logic [SOURCE_SLOTS-1:0] fresh_we;
  logic [SOURCE_SLOTS-1:0] free_slots;
  logic [SOURCE_SLOTS-1:0] first_free;
  logic                    any_hit;
  logic                    any_free;

  always_comb begin
    for (int i = 0; i < SOURCE_SLOTS; i++) begin
      hit[i]   = slot_vld_r[i] && (slot_dig_r[i] == origin_hash);
      newer[i] = (event_time > slot_time_r[i]) ||
                 ((event_time == slot_time_r[i]) && (sequence_uid > slot_uid_r[i]));
    end
  end

  // lowest free slot as a one-hot mask
  assign free_slots = ~slot_vld_r;
  assign first_free = free_slots & (~free_slots + SOURCE_SLOTS'(1));
  assign any_hit    = |hit;
  assign any_free   = |free_slots;
  assign upd_we     = hit & newer;
  assign fresh_we   = any_hit ? '0 : first_free;

  always_comb begin
    if (any_hit) begin
      dd_status = (|upd_we) ? ST_STORED : ST_DUP;
    end else begin
      dd_status = any_free ? ST_STORED : ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (adv) begin
      slot_vld_r <= slot_vld_r | fresh_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < SOURCE_SLOTS; i++) begin
        if (upd_we[i] || fresh_we[i]) begin
          slot_time_r[i] <= event_time;
          slot_uid_r[i]  <= sequence_uid;
        end
        if (fresh_we[i]) begin
          slot_dig_r[i] <= origin_hash;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/dral_alloc.sv
// ----------------------------------------------------------------------------
// dral_alloc
// Ring cursor, size check and round-up, wrap decision and result build.
// ----------------------------------------------------------------------------
`default_nettype none

module dral_alloc #(
  parameter int MAX_ENTRY_BYTES = dral_pkg::MAX_ENTRY_BYTES_DEF,
  parameter int HEADER_BYTES    = dral_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dral_pkg::OFF_W-1:0]    cfg_ring_size,
  input  logic                          adv,
  input  dral_pkg::status_t             dd_status,
  input  logic [dral_pkg::SIZE_W-1:0]   entry_bytes,
  output dral_pkg::res_t                res
);
  import dral_pkg::*;

  localparam logic [SIZE_W-1:0] MaxBytes = SIZE_W'(MAX_ENTRY_BYTES);
  localparam logic [SIZE_W-1:0] HdrBytes = SIZE_W'(HEADER_BYTES);

  logic [OFF_W-1:0] ring_size_r;
  logic [OFF_W-1:0] cursor_offset_r;
  logic [OFF_W-1:0] cursor_end_r;

  logic             size_ok;
  logic             store;
  logic             wrap;
  logic [RND_W-1:0] rounded;
  logic [OFF_W:0]   cont_sum;
  logic [OFF_W:0]   end_sum;
  logic [OFF_W-1:0] pos;

  assign size_ok  = (entry_bytes > HdrBytes) && (entry_bytes <= MaxBytes);
  assign rounded  = ({1'b0, entry_bytes} + RND_W'(7)) & ROUND_MASK[RND_W-1:0];
  assign cont_sum = {1'b0, cursor_end_r} + (OFF_W+1)'(rounded);
  assign wrap     = cont_sum >= {1'b0, ring_size_r};
  // empty ring, or record would reach the end: restart past the base header
  assign pos      = ((cursor_offset_r == '0) || wrap) ? RING_START : cursor_end_r;
  assign end_sum  = {1'b0, pos} + (OFF_W+1)'(rounded);
  assign store    = (dd_status == ST_STORED) && size_ok;

  always_comb begin
    res = '0;
    if (dd_status != ST_STORED) begin
      res.status = dd_status;
    end else if (!size_ok) begin
      res.status = ST_SIZE;
    end else begin
      res.status       = ST_STORED;
      res.write_offset = pos;
      res.prev_offset  = cursor_offset_r;
      res.end_offset   = end_sum[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r     <= RING_SIZE_RST;
      cursor_offset_r <= '0;
      cursor_end_r    <= '0;
    end else begin
      if (cfg_we) begin
        ring_size_r <= cfg_ring_size;
      end
      if (adv && store) begin
        cursor_offset_r <= pos;
        cursor_end_r    <= end_sum[OFF_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/dedup_ring_log_allocator.sv
// ----------------------------------------------------------------------------
// dedup_ring_log_allocator
// Drops stale log records per source and allocates ring space for the rest.
// ----------------------------------------------------------------------------
// Input channel (in_*): one record descriptor per transfer. Output channel
// (out_*): exactly one result per record, in order: status plus the write,
// previous and end offsets (offsets are 0 unless the record was stored).
// Config channel (cfg_*): writes ring_size; always ready, write only while
// the block is idle.
// Timing: a record held in the input register is looked up in the SOURCE_SLOTS-entry
// (32 by default) associative source table and allocated in the same cycle; its
// result is registered into the output register when that register is empty or
// being read. Throughput is one record per cycle while out_ready stays high; the
// table and ring cursor update in the cycle a record moves to the output
// register, so back-to-back records see each other's effect.
// Reset clears the source table valid bits, the ring cursor and sets
// ring_size to 131072. When the receiver stalls, the output register holds
// its result and the input register holds one more record; in_ready drops
// once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module dedup_ring_log_allocator #(
  parameter int MAX_ENTRY_BYTES = dral_pkg::MAX_ENTRY_BYTES_DEF,
  parameter int HEADER_BYTES    = dral_pkg::HEADER_BYTES_DEF,
  parameter int SOURCE_SLOTS    = dral_pkg::SOURCE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dral_pkg::OFF_W-1:0]   cfg_ring_size,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dral_pkg::DIG_W-1:0]   in_origin_hash,
  input  logic [dral_pkg::TIME_W-1:0]  in_event_time,
  input  logic [dral_pkg::UID_W-1:0]   in_sequence_uid,
  input  logic [dral_pkg::SIZE_W-1:0]  in_entry_bytes,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [dral_pkg::OFF_W-1:0]   out_write_offset,
  output logic [dral_pkg::OFF_W-1:0]   out_prev_offset,
  output logic [dral_pkg::OFF_W-1:0]   out_end_offset
);
  import dral_pkg::*;

  logic              in_vld_r;
  logic [DIG_W-1:0]  in_digest_r;
  logic [TIME_W-1:0] in_time_r;
  logic [UID_W-1:0]  in_uid_r;
  logic [SIZE_W-1:0] in_bytes_r;
  logic              out_vld_r;
  res_t              res_r;
  res_t              res;
  status_t           dd_status;
  logic              adv;
  logic              in_take;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign in_take   = in_valid && in_ready;

  dral_dedup #(
    .SOURCE_SLOTS (SOURCE_SLOTS)
  ) u_dedup (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .origin_hash  (in_digest_r),
    .event_time   (in_time_r),
    .sequence_uid (in_uid_r),
    .dd_status    (dd_status)
  );

  dral_alloc #(
    .MAX_ENTRY_BYTES (MAX_ENTRY_BYTES),
    .HEADER_BYTES    (HEADER_BYTES)
  ) u_alloc (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_ring_size (cfg_ring_size),
    .adv           (adv),
    .dd_status     (dd_status),
    .entry_bytes   (in_bytes_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_digest_r <= in_origin_hash;
      in_time_r   <= in_event_time;
      in_uid_r    <= in_sequence_uid;
      in_bytes_r  <= in_entry_bytes;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = res_r.status;
  assign out_write_offset = res_r.write_offset;
  assign out_prev_offset  = res_r.prev_offset;
  assign out_end_offset   = res_r.end_offset;

  // a record not stored carries no offsets
  a_unstored_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.status != ST_STORED)) |->
      ((res_r.write_offset == '0) && (res_r.prev_offset == '0) &&
       (res_r.end_offset == '0)))
    else $error("unstored result carries offsets");

  // a stored record is 8-aligned, past the base header, and ends after it starts
  a_stored_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (res_r.status == ST_STORED)) |->
      ((res_r.write_offset[2:0] == 3'b000) && (res_r.write_offset >= RING_START) &&
       (res_r.end_offset > res_r.write_offset)))
    else $error("stored record offsets malformed");

  // a held input record is neither lost nor changed while the output stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=>
      (in_vld_r && $stable(in_digest_r) && $stable(in_time_r) &&
       $stable(in_uid_r) && $stable(in_bytes_r)))
    else $error("held input record lost or changed");

  // a stored record's previous offset (the last stored write offset) is kept in the result register
  a_prev_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res.status == ST_STORED)) |=> (res_r.prev_offset == $past(res.prev_offset)))
    else $error("result register lost prev offset");

endmodule

`default_nettype wire
